/* hw/rtl/a64_instruction_subset_decoder_defines.svh */
// ----------------------------------------------------------------------------
// A64 decoder assertion macros
// Shared assertion shorthands, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef A64_INSTRUCTION_SUBSET_DECODER_DEFINES_SVH
`define A64_INSTRUCTION_SUBSET_DECODER_DEFINES_SVH

// same-cycle implication
`define A64D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define A64D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/a64d_pkg.sv */
// ----------------------------------------------------------------------------
// A64 decoder package
// Form codes and the entry type passed from the classifier to the field unit.
// ----------------------------------------------------------------------------
package a64d_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [2:0] SHIFT_LSR = 3'd1;
  localparam logic [2:0] SHIFT_ASR = 3'd2;
  localparam logic [2:0] SHIFT_ROR = 3'd3;

  typedef enum logic [5:0] {
    FORM_NOP, FORM_LDP_POST, FORM_LDP_PRE, FORM_LDP_OFF, FORM_STP_POST, FORM_STP_PRE,
    FORM_STP_OFF, FORM_LDR_POST, FORM_LDR_PRE, FORM_LDR_UOFF, FORM_LDR_LIT, FORM_LDR_REG,
    FORM_STR_POST, FORM_STR_PRE, FORM_STR_UOFF, FORM_STR_REG, FORM_MOVZ, FORM_MOVK,
    FORM_CMP_EXT, FORM_CMP_IMM, FORM_CMP_SREG, FORM_MOV_SP, FORM_ADD_IMM, FORM_ADDS_IMM,
    FORM_ADD_REG, FORM_ADDS_REG, FORM_SUB_IMM, FORM_SUBS_IMM, FORM_SUB_REG, FORM_SUBS_REG,
    FORM_LOG_BAD, FORM_TST_IMM, FORM_ANDS_IMM, FORM_TST_REG, FORM_ANDS_REG, FORM_BIC_REG,
    FORM_ORR_IMM, FORM_MVN, FORM_ORN_REG, FORM_MOV_REG, FORM_ORR_REG, FORM_EOR_REG,
    FORM_LSL, FORM_LSR, FORM_UXTB, FORM_UXTH, FORM_UBFM, FORM_ASR, FORM_SXTB, FORM_SXTH,
    FORM_SXTW, FORM_SBFX, FORM_SBFM, FORM_ROR, FORM_EXTR, FORM_BFC, FORM_BFI, FORM_BFM,
    FORM_BR, FORM_BLR, FORM_BCOND, FORM_B, FORM_CBZ, FORM_UNKNOWN
  } form_e;

  typedef struct packed {
    form_e       form;
    logic [31:0] word;
    logic [63:0] pc;
  } entry_t;

endpackage

/* hw/rtl/a64_instruction_subset_decoder.sv */
// ----------------------------------------------------------------------------
// A64 instruction subset decoder
// Decodes one A64 instruction word per item into form, registers and operands.
// ----------------------------------------------------------------------------
//  channel   dir  bits  contents
//  s_axis    in   96    instruction_word, pc_address
//  m_axis    out  176   decoded fields (170 used, upper bits zero)
//
//  One item per cycle sustained while neither side stalls; an accepted item
//  passes the classifier register, two-entry queue, then field register.
//  The field unit's 64-bit target add and mask expansion set the path depth.
//  Either side may stall; the queue keeps the classifier taking items while
//  the output register holds a result nobody has taken yet.
//  Reset clears only valid state and queue pointers; there is no clearing pass.
// ----------------------------------------------------------------------------
module a64_instruction_subset_decoder #(
  parameter int unsigned QueueDepth = a64d_pkg::QueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [31:0] instruction_word, [95:32] pc_address
  input  logic [95:0]  s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [5:0] form_code, [6] is_wide, [11:7] dest_reg, [16:12] base_reg,
  // [21:17] second_reg, [85:22] imm_value, [88:86] shift_kind,
  // [94:89] amount_a, [101:95] amount_b, [105:102] cond_code,
  // [169:106] target_address, [175:170] zero
  output logic [175:0] m_axis_tdata_o
);

  logic             fe_valid, fe_ready;
  a64d_pkg::entry_t fe_ent;
  logic             q_valid, q_ready;
  a64d_pkg::entry_t q_ent;
  logic [169:0]     be_data;

  // front: match patterns, resolve aliases
  a64d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .word_i      (s_axis_tdata_i[31:0]),
    .pc_i        (s_axis_tdata_i[95:32]),
    .ent_valid_o (fe_valid),
    .ent_ready_i (fe_ready),
    .ent_o       (fe_ent)
  );

  a64d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_ready_o (fe_ready),
    .push_data_i  (fe_ent),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_ent)
  );

  // back: field extraction, bitmask immediates, PC-relative targets
  a64d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_valid_i (q_valid),
    .ent_ready_o (q_ready),
    .ent_i       (q_ent),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (be_data)
  );

  assign m_axis_tdata_o = {6'd0, be_data};

endmodule

/* hw/rtl/a64d_front.sv */
// ----------------------------------------------------------------------------
// A64 decoder front end
// Accepts instruction items and resolves the form code, alias choice included.
// ----------------------------------------------------------------------------
module a64d_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [31:0]      word_i,
  input  logic [63:0]      pc_i,
  output logic             ent_valid_o,
  input  logic             ent_ready_i,
  output a64d_pkg::entry_t ent_o
);

  logic             valid_q, valid_d;
  a64d_pkg::entry_t ent_q, ent_d;
  a64d_pkg::form_e  form;
  logic             sf, nbit;
  logic [4:0]       rd, rn, rm;
  logic [5:0]       immr, imms;
  logic [1:0]       hh;
  logic [11:0]      i12;
  logic [6:0]       imms_p1;
  logic [31:0]      w;

  assign w       = word_i;
  assign sf      = w[31];
  assign nbit    = w[22];
  assign rd      = w[4:0];
  assign rn      = w[9:5];
  assign rm      = w[20:16];
  assign immr    = w[21:16];
  assign imms    = w[15:10];
  assign hh      = w[23:22];
  assign i12     = w[21:10];
  assign imms_p1 = {1'b0, imms} + 7'd1;

  always_comb begin
    form = a64d_pkg::FORM_UNKNOWN;
    priority if (w == 32'hD503201F) begin
      form = a64d_pkg::FORM_NOP;
    end else if (w[30:22] == 9'b010100011) begin
      form = a64d_pkg::FORM_LDP_POST;
    end else if (w[30:22] == 9'b010100111) begin
      form = a64d_pkg::FORM_LDP_PRE;
    end else if (w[30:22] == 9'b010100101) begin
      form = a64d_pkg::FORM_LDP_OFF;
    end else if (w[30:22] == 9'b010100010) begin
      form = a64d_pkg::FORM_STP_POST;
    end else if (w[30:22] == 9'b010100110) begin
      form = a64d_pkg::FORM_STP_PRE;
    end else if (w[30:22] == 9'b010100100) begin
      form = a64d_pkg::FORM_STP_OFF;
    end else if (w[31] && w[29:21] == 9'b111000010 && w[11:10] == 2'b01) begin
      form = a64d_pkg::FORM_LDR_POST;
    end else if (w[31] && w[29:21] == 9'b111000010 && w[11:10] == 2'b11) begin
      form = a64d_pkg::FORM_LDR_PRE;
    end else if (w[31] && w[29:22] == 8'b11100101) begin
      form = a64d_pkg::FORM_LDR_UOFF;
    end else if (!w[31] && w[29:24] == 6'b011000) begin
      form = a64d_pkg::FORM_LDR_LIT;
    end else if (w[31] && w[29:21] == 9'b111000011 && w[11:10] == 2'b10) begin
      form = a64d_pkg::FORM_LDR_REG;
    end else if (w[31] && w[29:21] == 9'b111000000 && w[11:10] == 2'b01) begin
      form = a64d_pkg::FORM_STR_POST;
    end else if (w[31] && w[29:21] == 9'b111000000 && w[11:10] == 2'b11) begin
      form = a64d_pkg::FORM_STR_PRE;
    end else if (w[31] && w[29:22] == 8'b11100100) begin
      form = a64d_pkg::FORM_STR_UOFF;
    end else if (w[31] && w[29:21] == 9'b111000001 && w[11:10] == 2'b10) begin
      form = a64d_pkg::FORM_STR_REG;
    end else if (w[30] && w[28:23] == 6'b100101) begin
      form = w[29] ? a64d_pkg::FORM_MOVK : a64d_pkg::FORM_MOVZ;
    end else if (w[30:21] == 10'b1101011001 && rd == 5'd31) begin
      form = a64d_pkg::FORM_CMP_EXT;
    end else if (w[30:23] == 8'b11100010 && rd == 5'd31) begin
      form = a64d_pkg::FORM_CMP_IMM;
    end else if (w[30:24] == 7'b1101011 && !w[21] && rd == 5'd31) begin
      form = a64d_pkg::FORM_CMP_SREG;
    end else if (w[30:24] == 7'b0010001) begin
      // MOV to/from SP alias
      form = ((rd == 5'd31 || rn == 5'd31) && hh == 2'd0 && i12 == 12'd0)
             ? a64d_pkg::FORM_MOV_SP : a64d_pkg::FORM_ADD_IMM;
    end else if (w[30:24] == 7'b0110001) begin
      form = a64d_pkg::FORM_ADDS_IMM;
    end else if (w[30:24] == 7'b0001011 && !w[21]) begin
      form = a64d_pkg::FORM_ADD_REG;
    end else if (w[30:24] == 7'b0101011 && !w[21]) begin
      form = a64d_pkg::FORM_ADDS_REG;
    end else if (w[30:24] == 7'b1010001) begin
      form = a64d_pkg::FORM_SUB_IMM;
    end else if (w[30:24] == 7'b1110001) begin
      form = a64d_pkg::FORM_SUBS_IMM;
    end else if (w[30:24] == 7'b1001011 && !w[21]) begin
      form = a64d_pkg::FORM_SUB_REG;
    end else if (w[30:24] == 7'b1101011 && !w[21]) begin
      form = a64d_pkg::FORM_SUBS_REG;
    end else if (w[29:23] == 7'b1100100) begin
      priority if (!sf && nbit) begin
        form = a64d_pkg::FORM_LOG_BAD;
      end else if (w[30]) begin
        form = (rd == 5'd31) ? a64d_pkg::FORM_TST_IMM : a64d_pkg::FORM_ANDS_IMM;
      end else begin
        form = a64d_pkg::FORM_ORR_IMM;
      end
    end else if (w[30:24] == 7'b1101010 && !w[21]) begin
      form = (rd == 5'd31) ? a64d_pkg::FORM_TST_REG : a64d_pkg::FORM_ANDS_REG;
    end else if (w[30:24] == 7'b0001010 && w[21]) begin
      form = a64d_pkg::FORM_BIC_REG;
    end else if (w[30:24] == 7'b0101010 && w[21]) begin
      form = (rn == 5'd31) ? a64d_pkg::FORM_MVN : a64d_pkg::FORM_ORN_REG;
    end else if (w[30:24] == 7'b0101010 && !w[21]) begin
      form = (rn == 5'd31) ? a64d_pkg::FORM_MOV_REG : a64d_pkg::FORM_ORR_REG;
    end else if (w[30:24] == 7'b1001010 && !w[21]) begin
      form = a64d_pkg::FORM_EOR_REG;
    end else if (w[30:23] == 8'b10100110) begin
      priority if (sf && imms != 6'h3f && imms_p1 == {1'b0, immr}) begin
        form = a64d_pkg::FORM_LSL;
      end else if (!sf && imms != 6'h1f && imms_p1 == {1'b0, immr}) begin
        form = a64d_pkg::FORM_LSL;
      end else if ((sf && imms == 6'h3f) || (!sf && imms == 6'h1f)) begin
        form = a64d_pkg::FORM_LSR;
      end else if (immr == 6'd0 && imms == 6'h07) begin
        form = a64d_pkg::FORM_UXTB;
      end else if (immr == 6'd0 && imms == 6'h0f) begin
        form = a64d_pkg::FORM_UXTH;
      end else begin
        form = a64d_pkg::FORM_UBFM;
      end
    end else if (w[30:23] == 8'b00100110) begin
      priority if ((sf && imms == 6'h3f) || (!sf && imms == 6'h1f)) begin
        form = a64d_pkg::FORM_ASR;
      end else if (immr == 6'd0 && imms == 6'h07) begin
        form = a64d_pkg::FORM_SXTB;
      end else if (immr == 6'd0 && imms == 6'h0f) begin
        form = a64d_pkg::FORM_SXTH;
      end else if (sf && immr == 6'd0 && imms == 6'h1f) begin
        form = a64d_pkg::FORM_SXTW;
      end else if (imms >= immr) begin
        form = a64d_pkg::FORM_SBFX;
      end else begin
        form = a64d_pkg::FORM_SBFM;
      end
    end else if (w[30:23] == 8'b00100111 && !w[21]) begin
      form = (rn == rm) ? a64d_pkg::FORM_ROR : a64d_pkg::FORM_EXTR;
    end else if (w[30:23] == 8'b01100110) begin
      if (imms < immr) begin
        form = (rn == 5'd31) ? a64d_pkg::FORM_BFC : a64d_pkg::FORM_BFI;
      end else begin
        form = a64d_pkg::FORM_BFM;
      end
    end else if (w[31:10] == 22'b1101011000011111000000 && rd == 5'd0) begin
      form = a64d_pkg::FORM_BR;
    end else if (w[31:10] == 22'b1101011000111111000000 && rd == 5'd0) begin
      form = a64d_pkg::FORM_BLR;
    end else if (w[31:24] == 8'b01010100 && !w[4]) begin
      form = a64d_pkg::FORM_BCOND;
    end else if (w[31:26] == 6'b000101) begin
      form = a64d_pkg::FORM_B;
    end else if (w[30:24] == 7'b0110100) begin
      form = a64d_pkg::FORM_CBZ;
    end else begin
      form = a64d_pkg::FORM_UNKNOWN;
    end
  end

  assign in_ready_o = !valid_q || ent_ready_i;

  always_comb begin
    valid_d = valid_q;
    ent_d   = ent_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
      if (in_valid_i) begin
        ent_d = '{form: form, word: word_i, pc: pc_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_valid_o = valid_q;
  assign ent_o       = ent_q;

endmodule

/* hw/rtl/a64d_queue.sv */
// ----------------------------------------------------------------------------
// A64 decoder queue
// Short FIFO that decouples the classifier from the field unit.
// ----------------------------------------------------------------------------
`include "a64_instruction_subset_decoder_defines.svh"

module a64d_queue #(
  parameter int unsigned Depth = a64d_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  a64d_pkg::entry_t push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output a64d_pkg::entry_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  a64d_pkg::entry_t    mem_q [Depth];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  `A64D_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CntW'(Depth), "queue count over depth")
  `A64D_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_q == $past(cnt_q) + CntW'(1), "count missed push")
  `A64D_ASSERT_NEXT(a_cnt_dn, pop && !push, cnt_q == $past(cnt_q) - CntW'(1), "count missed pop")
  `A64D_ASSERT_NOW(a_ptr_gap, cnt_q == '0, wr_q == rd_q, "pointers apart on empty queue")

endmodule

/* hw/rtl/a64d_back.sv */
// ----------------------------------------------------------------------------
// A64 decoder back end
// Extracts fields for a classified item, expands immediates, forms targets.
// ----------------------------------------------------------------------------
module a64d_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             ent_valid_i,
  output logic             ent_ready_o,
  input  a64d_pkg::entry_t ent_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [169:0]     out_data_o
);

  function automatic logic [63:0] decode_mask(logic n, logic [5:0] s6, logic [5:0] r6);
    logic [6:0]  key;
    logic [2:0]  len;
    logic [6:0]  e;
    logic [5:0]  lv, s, r;
    logic [63:0] m, emask;
    key = {n, ~s6};
    len = 3'd0;
    for (int i = 1; i < 7; i++) begin
      if (key[i]) len = 3'(i);
    end
    e  = 7'd1 << len;
    lv = 6'(e - 7'd1);
    s  = s6 & lv;
    r  = r6 & lv;
    if (len == 3'd0 || s == lv) begin
      return 64'd0;
    end
    m     = (64'd2 << s) - 64'd1;
    emask = (len == 3'd6) ? '1 : ((64'd1 << e) - 64'd1);
    if (r != 6'd0) begin
      m = ((m >> r) | (m << (e - {1'b0, r}))) & emask;
    end
    // replicate element up to 64 bits
    if (len == 3'd1) m = m | (m << 2);
    if (len <= 3'd2) m = m | (m << 4);
    if (len <= 3'd3) m = m | (m << 8);
    if (len <= 3'd4) m = m | (m << 16);
    if (len <= 3'd5) m = m | (m << 32);
    return m;
  endfunction

  logic [31:0]  w;
  logic         sf;
  logic [5:0]   immr, imms;
  logic [63:0]  sx7, sx9, sx19, sx26, i12x, i12s;
  logic [63:0]  mask;
  logic         wide;
  logic [4:0]   rd, rn, rm;
  logic [63:0]  imm, tgt;
  logic [2:0]   kind;
  logic [5:0]   amt_a;
  logic [6:0]   amt_b;
  logic [3:0]   cond;
  logic         use_tgt;
  logic         valid_q;
  logic [169:0] data_q;

  assign w    = ent_i.word;
  assign sf   = w[31];
  assign immr = w[21:16];
  assign imms = w[15:10];
  assign sx7  = {{57{w[21]}}, w[21:15]};
  assign sx9  = {{55{w[20]}}, w[20:12]};
  assign sx19 = {{43{w[23]}}, w[23:5], 2'b00};
  assign sx26 = {{36{w[25]}}, w[25:0], 2'b00};
  assign i12x = {52'd0, w[21:10]};
  assign i12s = i12x << w[31:30];
  assign mask = decode_mask(w[22], imms, immr) & (sf ? '1 : 64'h0000_0000_FFFF_FFFF);

  always_comb begin
    wide    = 1'b0;
    rd      = '0;
    rn      = '0;
    rm      = '0;
    imm     = '0;
    kind    = '0;
    amt_a   = '0;
    amt_b   = '0;
    cond    = '0;
    use_tgt = 1'b0;
    unique case (ent_i.form)
      a64d_pkg::FORM_LDP_POST, a64d_pkg::FORM_LDP_PRE, a64d_pkg::FORM_LDP_OFF,
      a64d_pkg::FORM_STP_POST, a64d_pkg::FORM_STP_PRE, a64d_pkg::FORM_STP_OFF: begin
        wide = sf; rd = w[4:0]; rn = w[9:5]; rm = w[14:10];
        imm  = sf ? (sx7 << 3) : (sx7 << 2);
      end
      a64d_pkg::FORM_LDR_POST, a64d_pkg::FORM_LDR_PRE,
      a64d_pkg::FORM_STR_POST, a64d_pkg::FORM_STR_PRE: begin
        wide = w[30]; rd = w[4:0]; rn = w[9:5]; imm = sx9;
      end
      a64d_pkg::FORM_LDR_UOFF, a64d_pkg::FORM_STR_UOFF: begin
        wide = w[30]; rd = w[4:0]; rn = w[9:5]; imm = i12s;
      end
      a64d_pkg::FORM_LDR_LIT: begin
        wide = w[30]; rd = w[4:0]; imm = sx19; use_tgt = 1'b1;
      end
      a64d_pkg::FORM_LDR_REG, a64d_pkg::FORM_STR_REG: begin
        wide = w[30]; rd = w[4:0]; rn = w[9:5]; rm = w[20:16];
        kind = w[15:13]; amt_a = w[12] ? {4'd0, w[31:30]} : 6'd0;
      end
      a64d_pkg::FORM_MOVZ, a64d_pkg::FORM_MOVK: begin
        wide = sf; rd = w[4:0]; imm = {48'd0, w[20:5]}; amt_b = {1'b0, w[22:21], 4'd0};
      end
      a64d_pkg::FORM_CMP_EXT: begin
        wide = sf; rd = w[4:0]; rn = w[9:5]; rm = w[20:16];
        kind = w[15:13]; amt_a = {3'd0, w[12:10]};
      end
      a64d_pkg::FORM_CMP_IMM: begin
        wide = sf; rd = w[4:0]; rn = w[9:5]; kind = {2'd0, w[22]};
        imm  = w[22] ? (i12x << 12) : i12x;
      end
      a64d_pkg::FORM_CMP_SREG, a64d_pkg::FORM_ADD_REG, a64d_pkg::FORM_ADDS_REG,
      a64d_pkg::FORM_SUB_REG, a64d_pkg::FORM_SUBS_REG, a64d_pkg::FORM_TST_REG,
      a64d_pkg::FORM_ANDS_REG, a64d_pkg::FORM_BIC_REG, a64d_pkg::FORM_MVN,
      a64d_pkg::FORM_ORN_REG, a64d_pkg::FORM_MOV_REG, a64d_pkg::FORM_ORR_REG,
      a64d_pkg::FORM_EOR_REG: begin
        wide = sf; rd = w[4:0]; rn = w[9:5]; rm = w[20:16];
        kind = {1'b0, w[23:22]}; amt_a = w[15:10];
      end
      a64d_pkg::FORM_MOV_SP, a64d_pkg::FORM_ADD_IMM, a64d_pkg::FORM_ADDS_IMM,
      a64d_pkg::FORM_SUB_IMM, a64d_pkg::FORM_SUBS_IMM: begin
        wide = sf; rd = w[4:0]; rn = w[9:5]; kind = {1'b0, w[23:22]};
        imm  = (w[23:22] == 2'd1) ? (i12x << 12) : i12x;
      end
      a64d_pkg::FORM_LOG_BAD: begin
        wide = sf; rd = w[4:0]; rn = w[9:5]; imm = mask; kind = {1'b0, w[30:29]};
      end
      a64d_pkg::FORM_TST_IMM, a64d_pkg::FORM_ANDS_IMM, a64d_pkg::FORM_ORR_IMM: begin
        wide = sf; rd = w[4:0]; rn = w[9:5]; imm = mask;
      end
      a64d_pkg::FORM_LSL: begin
        wide  = sf; rd = w[4:0]; rn = w[9:5];
        amt_a = sf ? (6'd63 - imms) : (6'd31 - imms);
      end
      a64d_pkg::FORM_LSR: begin
        wide = sf; rd = w[4:0]; rn = w[9:5]; kind = a64d_pkg::SHIFT_LSR; amt_a = immr;
      end
      a64d_pkg::FORM_ASR: begin
        wide = sf; rd = w[4:0]; rn = w[9:5]; kind = a64d_pkg::SHIFT_ASR; amt_a = immr;
      end
      a64d_pkg::FORM_UXTB, a64d_pkg::FORM_UXTH, a64d_pkg::FORM_SXTB,
      a64d_pkg::FORM_SXTH, a64d_pkg::FORM_SXTW: begin
        wide = sf; rd = w[4:0]; rn = w[9:5];
      end
      a64d_pkg::FORM_UBFM, a64d_pkg::FORM_SBFM, a64d_pkg::FORM_BFM: begin
        wide = sf; rd = w[4:0]; rn = w[9:5]; amt_a = immr; amt_b = {1'b0, imms};
      end
      a64d_pkg::FORM_SBFX: begin
        wide  = sf; rd = w[4:0]; rn = w[9:5]; amt_a = immr;
        amt_b = {1'b0, imms} - {1'b0, immr} + 7'd1;
      end
      a64d_pkg::FORM_ROR: begin
        wide = sf; rd = w[4:0]; rn = w[9:5]; rm = w[20:16];
        kind = a64d_pkg::SHIFT_ROR; amt_a = imms;
      end
      a64d_pkg::FORM_EXTR: begin
        wide = sf; rd = w[4:0]; rn = w[9:5]; rm = w[20:16]; amt_a = imms;
      end
      a64d_pkg::FORM_BFC, a64d_pkg::FORM_BFI: begin
        wide  = sf; rd = w[4:0]; rn = w[9:5];
        amt_a = (6'd0 - immr) & (sf ? 6'h3f : 6'h1f);
        amt_b = {1'b0, imms} + 7'd1;
      end
      a64d_pkg::FORM_BR, a64d_pkg::FORM_BLR: begin
        wide = 1'b1; rn = w[9:5];
      end
      a64d_pkg::FORM_BCOND: begin
        cond = w[3:0]; imm = sx19; use_tgt = 1'b1;
      end
      a64d_pkg::FORM_B: begin
        imm = sx26; use_tgt = 1'b1;
      end
      a64d_pkg::FORM_CBZ: begin
        wide = sf; rd = w[4:0]; imm = sx19; use_tgt = 1'b1;
      end
      default: begin
        // NOP and unmatched words carry only the form code
      end
    endcase
  end

  assign tgt = use_tgt ? (ent_i.pc + imm) : 64'd0;

  assign ent_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ent_ready_o) begin
      valid_q <= ent_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_ready_o && ent_valid_i) begin
      data_q <= {tgt, cond, amt_b, amt_a, kind, imm, rm, rn, rd, wide, ent_i.form};
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
